// ----- hdl/fmc_pkg.sv -----
// Shared constants, types and the CRC-32 byte step for the framed message checker.
`timescale 1ns / 1ps

package fmc_pkg;

   localparam int HeaderBytes = 32;
   localparam int HdrIdxWidth = $clog2(HeaderBytes);
   localparam int CrcSpan     = 28;
   localparam int CountWidth  = 17;

   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [31:0]           CrcInit  = 32'hFFFF_FFFF;
   localparam logic [31:0]           CrcPoly  = 32'hEDB8_8320;

   // Status codes carried on the result channel.
   localparam logic [3:0] STATUS_OK          = 4'd0;
   localparam logic [3:0] STATUS_SHORT       = 4'd1;
   localparam logic [3:0] STATUS_MAGIC       = 4'd2;
   localparam logic [3:0] STATUS_VERSION     = 4'd3;
   localparam logic [3:0] STATUS_HEADER_SIZE = 4'd4;
   localparam logic [3:0] STATUS_TOO_LARGE   = 4'd5;
   localparam logic [3:0] STATUS_LENGTH      = 4'd6;
   localparam logic [3:0] STATUS_HEADER_CRC  = 4'd7;
   localparam logic [3:0] STATUS_PAYLOAD_CRC = 4'd8;
   localparam logic [3:0] STATUS_TYPE        = 4'd9;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAGIC     = 2'd0;
   localparam logic [1:0] CSR_VERSION   = 2'd1;
   localparam logic [1:0] CSR_LIMIT     = 2'd2;
   localparam logic [1:0] CSR_TYPE_MASK = 2'd3;

   typedef logic [HeaderBytes-1:0][7:0] header_type;

   typedef struct packed {
      logic [31:0] magic;
      logic [7:0]  version;
      logic [15:0] payload_limit;
      logic [15:0] type_mask;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] message_type;
      logic [15:0] message_flags;
      logic [31:0] lease_number;
      logic [31:0] sequence_number;
      logic [31:0] acked_sequence;
      logic [15:0] body_length;
   } result_type;

   // Reflected CRC-32 update over one byte, one polynomial step per bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// ----- hdl/fmc_check.sv -----
// Frame verdict logic: ordered header and CRC checks and the result fields.
`timescale 1ns / 1ps

module fmc_check (
   input  fmc_pkg::header_type              header,
   input  logic [fmc_pkg::CountWidth-1:0]   byte_count,
   input  logic [31:0]                      header_crc,
   input  logic [31:0]                      payload_crc,
   input  fmc_pkg::cfg_type                 cfg,
   output fmc_pkg::result_type              result
);
   import fmc_pkg::*;

   logic [31:0]           magic_word;
   logic [15:0]           body;
   logic [15:0]           msg_type;
   logic [31:0]           crc_field_header;
   logic [31:0]           crc_field_payload;
   logic [CountWidth-1:0] expected_len;
   logic [3:0]            status;

   assign magic_word        = {header[3], header[2], header[1], header[0]};
   assign body              = {header[11], header[10]};
   assign msg_type          = {header[7], header[6]};
   assign crc_field_header  = {header[31], header[30], header[29], header[28]};
   assign crc_field_payload = {header[27], header[26], header[25], header[24]};
   assign expected_len      = CountWidth'(HeaderBytes) + {{(CountWidth-16){1'b0}}, body};

   // The first failing check decides the status.
   always_comb begin
      priority if (byte_count < CountWidth'(HeaderBytes)) begin
         status = STATUS_SHORT;
      end else if (magic_word != cfg.magic) begin
         status = STATUS_MAGIC;
      end else if (header[4] != cfg.version) begin
         status = STATUS_VERSION;
      end else if (header[5] != 8'(HeaderBytes)) begin
         status = STATUS_HEADER_SIZE;
      end else if (body > cfg.payload_limit) begin
         status = STATUS_TOO_LARGE;
      end else if (byte_count != expected_len) begin
         status = STATUS_LENGTH;
      end else if (crc_field_header != header_crc) begin
         status = STATUS_HEADER_CRC;
      end else if (crc_field_payload != ~payload_crc) begin
         status = STATUS_PAYLOAD_CRC;
      end else if ((msg_type > 16'd15) || !cfg.type_mask[msg_type[3:0]]) begin
         status = STATUS_TYPE;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      result        = '0;
      result.status = status;
      if (status == STATUS_OK) begin
         result.message_type    = msg_type;
         result.message_flags   = {header[9], header[8]};
         result.lease_number    = {header[15], header[14], header[13], header[12]};
         result.sequence_number = {header[19], header[18], header[17], header[16]};
         result.acked_sequence  = {header[23], header[22], header[21], header[20]};
         result.body_length     = body;
      end
   end

endmodule

// ----- hdl/framed_message_checker.sv -----
// Top level of the framed message checker: byte capture, running CRCs and result register.
`timescale 1ns / 1ps

// The checker takes one frame byte per clock on the request channel while
// req_stall is low, with req_end_of_frame set on the last byte of each frame.
// The first 32 bytes are held as a little-endian header while a reflected
// CRC-32 runs over header bytes 0 to 27 and a second one over the payload.
// Frames may follow each other with no gap. The byte carrying the end-of-frame
// flag produces exactly one result transaction on the response channel: it is
// stored into the frame registers, and the verdict computed from them then
// moves into the response register; other bytes produce nothing. The
// result holds a status code and, only when the status is ok, the decoded
// header fields (all zero otherwise). A pending verdict that cannot move into
// the response register stalls the request channel until it does. The byte
// count saturates, so very long frames always fail the length check.
// Configuration registers are written through the csr port and should only be
// changed while no frame is in flight.

module framed_message_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_end_of_frame,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_check_status,
   output logic [15:0] rsp_message_type,
   output logic [15:0] rsp_message_flags,
   output logic [31:0] rsp_lease_number,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_acked_sequence,
   output logic [15:0] rsp_body_length,

   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fmc_pkg::*;

   // Configuration.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Frame state. fresh_ff means the last transaction closed a frame, so the
   // stored count and CRCs are stale and the next byte starts from reset values.
   header_type            header_ff;
   header_type            header_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [31:0]           crc_ff;
   logic [31:0]           crc_in;
   logic [31:0]           hcrc_ff;
   logic [31:0]           hcrc_in;
   logic                  fresh_ff;
   logic                  fresh_in;

   // A frame whose last byte was stored and whose verdict still has to move on.
   logic                  eval_ff;
   logic                  eval_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   result_type            rsp_ff;
   result_type            rsp_in;

   logic                  req_take;
   logic                  rsp_load;
   logic [CountWidth-1:0] pos;
   logic [31:0]           crc_start;
   logic [31:0]           crc_next;
   result_type            verdict;

   assign rsp_load  = eval_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = eval_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAGIC:     cfg_in.magic         = csr_wdata;
            CSR_VERSION:   cfg_in.version       = csr_wdata[7:0];
            CSR_LIMIT:     cfg_in.payload_limit = csr_wdata[15:0];
            CSR_TYPE_MASK: cfg_in.type_mask     = csr_wdata[15:0];
         endcase
      end
   end

   // Byte position and CRC seen by the incoming byte.
   assign pos       = fresh_ff ? '0 : count_ff;
   assign crc_start = fresh_ff ? CrcInit : crc_ff;
   assign crc_next  = crc_byte(crc_start, req_frame_byte);

   always_comb begin
      header_in = header_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      hcrc_in   = hcrc_ff;
      fresh_in  = fresh_ff;
      if (req_take) begin
         fresh_in = req_end_of_frame;
         hcrc_in  = fresh_ff ? '0 : hcrc_ff;
         crc_in   = crc_start;
         if (pos < CountWidth'(HeaderBytes)) begin
            header_in[pos[HdrIdxWidth-1:0]] = req_frame_byte;
         end
         if (pos < CountWidth'(CrcSpan)) begin
            // The header CRC closes on its last byte and the payload CRC restarts.
            if (pos == CountWidth'(CrcSpan - 1)) begin
               hcrc_in = ~crc_next;
               crc_in  = CrcInit;
            end else begin
               crc_in  = crc_next;
            end
         end else if (pos >= CountWidth'(HeaderBytes)) begin
            crc_in = crc_next;
         end
         count_in = (pos == CountMax) ? CountMax : pos + 1'b1;
      end
   end

   fmc_check u_check (
      .header      (header_ff),
      .byte_count  (count_ff),
      .header_crc  (hcrc_ff),
      .payload_crc (crc_ff),
      .cfg         (cfg_ff),
      .result      (verdict)
   );

   assign eval_in      = req_take ? req_end_of_frame : (eval_ff && !rsp_load);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = rsp_load ? verdict : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic         <= '0;
         cfg_ff.version       <= '0;
         cfg_ff.payload_limit <= 16'd1024;
         cfg_ff.type_mask     <= 16'd4094;
         count_ff             <= '0;
         crc_ff               <= CrcInit;
         hcrc_ff              <= '0;
         fresh_ff             <= 1'b0;
         eval_ff              <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff               <= cfg_in;
         count_ff             <= count_in;
         crc_ff               <= crc_in;
         hcrc_ff              <= hcrc_in;
         fresh_ff             <= fresh_in;
         eval_ff              <= eval_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_check_status    = rsp_ff.status;
   assign rsp_message_type    = rsp_ff.message_type;
   assign rsp_message_flags   = rsp_ff.message_flags;
   assign rsp_lease_number    = rsp_ff.lease_number;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_acked_sequence  = rsp_ff.acked_sequence;
   assign rsp_body_length     = rsp_ff.body_length;

endmodule

// ----- hdl/fmc_monitor.sv -----
// Port-level assertions for the framed message checker and their bind.
`timescale 1ns / 1ps

module fmc_monitor (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_end_of_frame,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_check_status,
   input logic [15:0] rsp_message_type,
   input logic [15:0] rsp_message_flags,
   input logic [31:0] rsp_lease_number,
   input logic [31:0] rsp_sequence_number,
   input logic [31:0] rsp_acked_sequence,
   input logic [15:0] rsp_body_length
);
   import fmc_pkg::*;

   // A stalled result stays offered with the same status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_check_status))
      else $error("stalled result changed or dropped");

   // Decoded fields are only shown for a frame that passed every check.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_check_status != STATUS_OK) |->
         (rsp_message_type == '0) && (rsp_message_flags == '0) &&
         (rsp_lease_number == '0) && (rsp_sequence_number == '0) &&
         (rsp_acked_sequence == '0) && (rsp_body_length == '0))
      else $error("fields not cleared on a failed frame");

   // A new result must come from a last byte taken earlier on the request channel.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_end_of_frame, 2))
      else $error("result without a preceding end of frame");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind framed_message_checker fmc_monitor u_monitor (.*);

// ----- bench/fmc_verdict_monitor.sv -----
// CRC helper and the monitor that predicts and checks framed message verdicts.
`timescale 1ns / 1ps

package fmc_crc_pkg;

   // Reflected CRC-32 over one byte, data bits taken LSB first.
   function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] data);
      logic [31:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ data[i]) begin
            r = (r >> 1) ^ fmc_pkg::CrcPoly;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

module fmc_verdict_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_end_of_frame,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_check_status,
   input  logic [15:0] rsp_message_type,
   input  logic [15:0] rsp_message_flags,
   input  logic [31:0] rsp_lease_number,
   input  logic [31:0] rsp_sequence_number,
   input  logic [31:0] rsp_acked_sequence,
   input  logic [15:0] rsp_body_length,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_verdicts
);
   import fmc_pkg::*;
   import fmc_crc_pkg::*;

   logic [31:0] cfg_magic;
   logic [7:0]  cfg_version;
   logic [15:0] cfg_limit;
   logic [15:0] cfg_mask;

   logic [CountWidth-1:0] bytes_seen;
   logic [7:0]            hdr_bytes [HeaderBytes];
   logic [31:0]           crc_acc;
   logic [31:0]           hdr_crc_final;

   result_type expected_verdicts [$];
   result_type observed;

   function automatic logic [15:0] header_half(input int at);
      return {hdr_bytes[at + 1], hdr_bytes[at]};
   endfunction

   function automatic logic [31:0] header_word(input int at);
      return {header_half(at + 2), header_half(at)};
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic is_last);
      result_type v;
      logic [15:0] body;
      logic [15:0] mtype;
      int          total;
      if (bytes_seen < HeaderBytes) hdr_bytes[bytes_seen[4:0]] = b;
      if (bytes_seen < CrcSpan) begin
         crc_acc = crc32_step(crc_acc, b);
         if (bytes_seen == CrcSpan - 1) begin
            hdr_crc_final = ~crc_acc;
            crc_acc = CrcInit;
         end
      end else if (bytes_seen >= HeaderBytes) begin
         crc_acc = crc32_step(crc_acc, b);
      end
      if (bytes_seen != CountMax) bytes_seen = bytes_seen + 1'b1;
      if (!is_last) return;

      total = int'(bytes_seen);
      v = '0;
      if (total < HeaderBytes) begin
         v.status = STATUS_SHORT;
      end else begin
         body  = header_half(10);
         mtype = header_half(6);
         if (header_word(0) != cfg_magic) v.status = STATUS_MAGIC;
         else if (hdr_bytes[4] != cfg_version) v.status = STATUS_VERSION;
         else if (int'(hdr_bytes[5]) != HeaderBytes) v.status = STATUS_HEADER_SIZE;
         else if (body > cfg_limit) v.status = STATUS_TOO_LARGE;
         else if (total != HeaderBytes + int'(body)) v.status = STATUS_LENGTH;
         else if (header_word(28) != hdr_crc_final) v.status = STATUS_HEADER_CRC;
         else if (header_word(24) != ~crc_acc) v.status = STATUS_PAYLOAD_CRC;
         else if (mtype > 15 || !cfg_mask[mtype[3:0]]) v.status = STATUS_TYPE;
         else v.status = STATUS_OK;
         if (v.status == STATUS_OK) begin
            v.message_type    = mtype;
            v.message_flags   = header_half(8);
            v.lease_number    = header_word(12);
            v.sequence_number = header_word(16);
            v.acked_sequence  = header_word(20);
            v.body_length     = body;
         end
      end
      expected_verdicts.push_back(v);
      bytes_seen    = '0;
      crc_acc       = CrcInit;
      hdr_crc_final = '0;
   endtask

   task automatic check_verdict(input result_type got);
      result_type want;
      if (expected_verdicts.size() == 0) begin
         $error("unexpected result transaction, check_status %0d", got.status);
         mismatch_count++;
         return;
      end
      want = expected_verdicts.pop_front();
      if (got.status != want.status) begin
         $error("check_status: expected %0d, actual %0d", want.status, got.status);
         mismatch_count++;
      end
      if (got.message_type != want.message_type) begin
         $error("message_type: expected %0h, actual %0h", want.message_type, got.message_type);
         mismatch_count++;
      end
      if (got.message_flags != want.message_flags) begin
         $error("message_flags: expected %0h, actual %0h", want.message_flags,
                got.message_flags);
         mismatch_count++;
      end
      if (got.lease_number != want.lease_number) begin
         $error("lease_number: expected %0h, actual %0h", want.lease_number, got.lease_number);
         mismatch_count++;
      end
      if (got.sequence_number != want.sequence_number) begin
         $error("sequence_number: expected %0h, actual %0h", want.sequence_number,
                got.sequence_number);
         mismatch_count++;
      end
      if (got.acked_sequence != want.acked_sequence) begin
         $error("acked_sequence: expected %0h, actual %0h", want.acked_sequence,
                got.acked_sequence);
         mismatch_count++;
      end
      if (got.body_length != want.body_length) begin
         $error("body_length: expected %0d, actual %0d", want.body_length, got.body_length);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_magic     = '0;
         cfg_version   = '0;
         cfg_limit     = 16'd1024;
         cfg_mask      = 16'h0FFE;
         bytes_seen    = '0;
         crc_acc       = CrcInit;
         hdr_crc_final = '0;
         for (int i = 0; i < HeaderBytes; i++) hdr_bytes[i] = '0;
         expected_verdicts.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAGIC:     cfg_magic   = csr_wdata;
               CSR_VERSION:   cfg_version = csr_wdata[7:0];
               CSR_LIMIT:     cfg_limit   = csr_wdata[15:0];
               CSR_TYPE_MASK: cfg_mask    = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_byte(req_frame_byte, req_end_of_frame);
         if (rsp_valid && !rsp_stall) begin
            observed.status          = rsp_check_status;
            observed.message_type    = rsp_message_type;
            observed.message_flags   = rsp_message_flags;
            observed.lease_number    = rsp_lease_number;
            observed.sequence_number = rsp_sequence_number;
            observed.acked_sequence  = rsp_acked_sequence;
            observed.body_length     = rsp_body_length;
            check_verdict(observed);
         end
      end
      pending_verdicts <= expected_verdicts.size();
   end

endmodule

// ----- bench/framed_message_checker_tb.sv -----
// Testbench top for the framed message checker: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

// The bench builds whole frames (a 32-byte little-endian header followed by a
// payload) and feeds them byte by byte through the request channel. Most
// frames are well formed with random content so that the block reaches its
// later checks and the ok path; the rest carry exactly one defect (short,
// bad magic, version, header size, oversize body, wrong length, corrupted
// header or payload CRC, bad type) or are plain noise. The monitor module
// sitting beside the block predicts every verdict and compares each result
// transaction, so this top only creates stimulus and reports the outcome.
module framed_message_checker_tb;
   import fmc_pkg::*;
   import fmc_crc_pkg::*;

   // Longest stretch of cycles with no transaction on either channel.
   localparam int QuietLimit = 2000;
   // Byte budget of one random configuration phase.
   localparam int PhaseBytes = 180;

   typedef enum int {
      FRAME_GOOD,
      FRAME_SHORT,
      FRAME_NOISE,
      FRAME_BAD_MAGIC,
      FRAME_BAD_VERSION,
      FRAME_BAD_HSIZE,
      FRAME_OVERSIZE,
      FRAME_BAD_LENGTH,
      FRAME_BAD_HCRC,
      FRAME_BAD_PCRC,
      FRAME_BAD_TYPE
   } frame_kind_type;

   // Everything needed to lay out one frame on the wire.
   typedef struct {
      bit          raw;
      int          raw_len;
      logic [31:0] magic;
      logic [7:0]  version;
      logic [7:0]  hsize;
      logic [15:0] mtype;
      logic [15:0] flags;
      logic [15:0] body;
      logic [31:0] lease;
      logic [31:0] seq;
      logic [31:0] ack;
      int          payload_len;
      bit          bad_hcrc;
      bit          bad_pcrc;
   } frame_recipe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_frame_byte = '0;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_check_status;
   logic [15:0] rsp_message_type;
   logic [15:0] rsp_message_flags;
   logic [31:0] rsp_lease_number;
   logic [31:0] rsp_sequence_number;
   logic [31:0] rsp_acked_sequence;
   logic [15:0] rsp_body_length;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int mismatch_count;
   int pending_verdicts;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;

   // The bench's own copy of the register values, used to aim the frames.
   logic [31:0] cur_magic   = '0;
   logic [7:0]  cur_version = '0;
   logic [15:0] cur_limit   = 16'd1024;
   logic [15:0] cur_mask    = 16'h0FFE;

   logic [7:0] frame_bytes [$];

   always #5 clock = ~clock;

   framed_message_checker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_frame_byte      (req_frame_byte),
      .req_end_of_frame    (req_end_of_frame),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_check_status    (rsp_check_status),
      .rsp_message_type    (rsp_message_type),
      .rsp_message_flags   (rsp_message_flags),
      .rsp_lease_number    (rsp_lease_number),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_acked_sequence  (rsp_acked_sequence),
      .rsp_body_length     (rsp_body_length),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   fmc_verdict_monitor monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_frame_byte      (req_frame_byte),
      .req_end_of_frame    (req_end_of_frame),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_check_status    (rsp_check_status),
      .rsp_message_type    (rsp_message_type),
      .rsp_message_flags   (rsp_message_flags),
      .rsp_lease_number    (rsp_lease_number),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_acked_sequence  (rsp_acked_sequence),
      .rsp_body_length     (rsp_body_length),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .pending_verdicts    (pending_verdicts)
   );

   // The response side stalls on about a third of the cycles while idling is
   // enabled, independently of what the block is presenting.
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 34);
   end

   // Watchdog: a run in which neither channel moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] flip_bits();
      logic [31:0] m;
      do m = $urandom; while (m == 0);
      return m;
   endfunction

   // Draws a frame of the given kind against the current register values.
   // A well-formed frame is the starting point and at most one defect is applied.
   function automatic frame_recipe_type plan_frame(input frame_kind_type kind);
      frame_recipe_type r;
      int small_cap;
      int big_cap;
      small_cap = (cur_limit < 24) ? int'(cur_limit) : 24;
      big_cap   = (cur_limit < 300) ? int'(cur_limit) : 300;

      r.raw      = 1'b0;
      r.raw_len  = 0;
      r.magic    = cur_magic;
      r.version  = cur_version;
      r.hsize    = 8'(HeaderBytes);
      r.flags    = 16'($urandom);
      r.lease    = $urandom;
      r.seq      = $urandom;
      r.ack      = $urandom;
      r.bad_hcrc = 1'b0;
      r.bad_pcrc = 1'b0;
      if (cur_mask == 0) begin
         r.mtype = 16'($urandom_range(0, 15));
      end else begin
         do r.mtype = 16'($urandom_range(0, 15)); while (!cur_mask[r.mtype[3:0]]);
      end
      if ($urandom_range(99) < 85) r.payload_len = $urandom_range(0, small_cap);
      else r.payload_len = $urandom_range(0, big_cap);
      r.body = 16'(r.payload_len);

      // An oversize body cannot exist when the limit is already at its top.
      if (kind == FRAME_OVERSIZE && cur_limit == 16'hFFFF) kind = FRAME_BAD_LENGTH;

      case (kind)
         FRAME_SHORT: begin
            r.raw     = 1'b1;
            r.raw_len = $urandom_range(1, HeaderBytes - 1);
         end
         FRAME_NOISE: begin
            r.raw     = 1'b1;
            r.raw_len = $urandom_range(HeaderBytes, 64);
         end
         FRAME_BAD_MAGIC:   r.magic = r.magic ^ flip_bits();
         FRAME_BAD_VERSION: r.version = r.version ^ 8'($urandom_range(1, 255));
         FRAME_BAD_HSIZE: begin
            do r.hsize = 8'($urandom_range(0, 255)); while (r.hsize == HeaderBytes);
         end
         FRAME_OVERSIZE: begin
            r.body        = 16'($urandom_range(int'(cur_limit) + 1, 65535));
            r.payload_len = $urandom_range(0, 8);
         end
         FRAME_BAD_LENGTH: begin
            // The frame ends either early or late relative to the body length.
            if (r.body != 0 && $urandom_range(1) == 1) r.payload_len = int'(r.body) - 1;
            else r.payload_len = int'(r.body) + int'($urandom_range(1, 3));
         end
         FRAME_BAD_HCRC: r.bad_hcrc = 1'b1;
         FRAME_BAD_PCRC: r.bad_pcrc = 1'b1;
         FRAME_BAD_TYPE: begin
            if (cur_mask == 16'hFFFF || $urandom_range(1) == 1) begin
               r.mtype = 16'($urandom_range(16, 65535));
            end else begin
               do r.mtype = 16'($urandom_range(0, 15)); while (cur_mask[r.mtype[3:0]]);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Lays out the recipe as bytes: payload CRC first, since it sits inside
   // the span that the header CRC covers.
   task automatic compose_frame(input frame_recipe_type r);
      logic [7:0]  hdr [HeaderBytes];
      logic [7:0]  payload [$];
      logic [7:0]  b;
      logic [31:0] pcrc;
      logic [31:0] hcrc;
      frame_bytes.delete();
      if (r.raw) begin
         repeat (r.raw_len) frame_bytes.push_back(8'($urandom));
         return;
      end
      pcrc = CrcInit;
      for (int i = 0; i < r.payload_len; i++) begin
         b = 8'($urandom);
         payload.push_back(b);
         pcrc = crc32_step(pcrc, b);
      end
      pcrc = ~pcrc;
      if (r.bad_pcrc) pcrc = pcrc ^ flip_bits();

      {hdr[3], hdr[2], hdr[1], hdr[0]}     = r.magic;
      hdr[4]                               = r.version;
      hdr[5]                               = r.hsize;
      {hdr[7], hdr[6]}                     = r.mtype;
      {hdr[9], hdr[8]}                     = r.flags;
      {hdr[11], hdr[10]}                   = r.body;
      {hdr[15], hdr[14], hdr[13], hdr[12]} = r.lease;
      {hdr[19], hdr[18], hdr[17], hdr[16]} = r.seq;
      {hdr[23], hdr[22], hdr[21], hdr[20]} = r.ack;
      {hdr[27], hdr[26], hdr[25], hdr[24]} = pcrc;

      hcrc = CrcInit;
      for (int i = 0; i < CrcSpan; i++) hcrc = crc32_step(hcrc, hdr[i]);
      hcrc = ~hcrc;
      if (r.bad_hcrc) hcrc = hcrc ^ flip_bits();
      {hdr[31], hdr[30], hdr[29], hdr[28]} = hcrc;

      for (int i = 0; i < HeaderBytes; i++) frame_bytes.push_back(hdr[i]);
      foreach (payload[i]) frame_bytes.push_back(payload[i]);
   endtask

   // Offers one byte and holds it until the block takes it. Random idle
   // cycles go in front of the byte; without them valid stays high and only
   // the payload moves, so frames can run back to back.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_frame_byte   <= b;
      req_end_of_frame <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic send_planned(input frame_recipe_type r);
      compose_frame(r);
      send_frame();
   endtask

   // Drops valid and waits until every predicted verdict has come back and
   // the block's two-stage result path has emptied.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles while the block is idle.
   task automatic program_registers(input logic [31:0] magic, input logic [7:0] version,
                                    input logic [15:0] limit, input logic [15:0] mask);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_MAGIC;
      csr_wdata <= magic;
      @(posedge clock);
      csr_index <= CSR_VERSION;
      csr_wdata <= {24'd0, version};
      @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= {16'd0, limit};
      @(posedge clock);
      csr_index <= CSR_TYPE_MASK;
      csr_wdata <= {16'd0, mask};
      @(posedge clock);
      csr_write   <= 1'b0;
      cur_magic   = magic;
      cur_version = version;
      cur_limit   = limit;
      cur_mask    = mask;
   endtask

   // Random frames until the phase has used its byte budget and produced a
   // reasonable number of verdicts. About two frames in three are clean.
   task automatic run_phase();
      frame_kind_type kind;
      int bytes_used;
      int frames_sent;
      bytes_used  = 0;
      frames_sent = 0;
      while (bytes_used < PhaseBytes || frames_sent < 4) begin
         if ($urandom_range(99) < 65) kind = FRAME_GOOD;
         else kind = frame_kind_type'($urandom_range(FRAME_SHORT, FRAME_BAD_TYPE));
         compose_frame(plan_frame(kind));
         bytes_used += frame_bytes.size();
         frames_sent++;
         send_frame();
      end
   endtask

   function automatic logic [15:0] random_limit();
      return 16'($urandom_range(0, 48));
   endfunction

   initial begin
      frame_recipe_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset register values.
      // A single byte and a 31-byte frame both end before the header is complete.
      r = plan_frame(FRAME_SHORT);
      r.raw_len = 1;
      send_planned(r);
      r.raw_len = HeaderBytes - 1;
      send_planned(r);

      // Clean frames with extreme field values, one with an empty payload
      // whose CRC field must read as zero.
      r = plan_frame(FRAME_GOOD);
      r.mtype = 16'd1;
      r.flags = 16'hFFFF;
      r.lease = 32'hFFFF_FFFF;
      r.seq = 32'h0;
      r.ack = 32'hFFFF_FFFF;
      r.body = 16'd0;
      r.payload_len = 0;
      send_planned(r);
      r.mtype = 16'd11;
      r.flags = 16'h0;
      r.lease = 32'h0;
      r.seq = 32'hFFFF_FFFF;
      r.ack = 32'h0;
      r.body = 16'd5;
      r.payload_len = 5;
      send_planned(r);

      // Plain noise, then one frame per remaining defect, in the order the block checks them.
      for (int k = FRAME_NOISE; k <= FRAME_BAD_TYPE; k++) begin
         send_planned(plan_frame(frame_kind_type'(k)));
      end

      // Type zero is masked out after reset; the largest type is never valid.
      r = plan_frame(FRAME_GOOD);
      r.mtype = 16'd0;
      send_planned(r);
      r.mtype = 16'hFFFF;
      send_planned(r);

      // Frame length off by one in both directions.
      r = plan_frame(FRAME_GOOD);
      r.body = 16'd3;
      r.payload_len = 2;
      send_planned(r);
      r.payload_len = 4;
      send_planned(r);

      // Random phases, starting with both register extremes. The third phase
      // runs with no idling on either channel.
      program_registers(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      run_phase();
      program_registers(32'h0, 8'h0, 16'h0, 16'h0);
      run_phase();
      idle_on = 1'b0;
      program_registers($urandom, 8'($urandom), random_limit(), 16'($urandom));
      run_phase();
      idle_on = 1'b1;
      repeat (2) begin
         program_registers($urandom, 8'($urandom), random_limit(), 16'($urandom));
         run_phase();
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
